[rtl/dtcf_pkg.sv]
// ============================================================================
// dtcf_pkg
// Shared types and constants for the double to custom float converter.
// ============================================================================
package dtcf_pkg;

    // binary64 layout
    localparam int unsigned DBL_W     = 64;
    localparam int unsigned FRAC_W    = 52;
    localparam int unsigned DEXP_W    = 11;
    localparam logic [DEXP_W-1:0] DEXP_ONES = 11'h7FF;
    localparam logic [11:0]   DBL_BIAS = 12'd1023;

    // leading-one search: 7 groups of 8 over the zero-padded fraction
    localparam int unsigned GRP_W = 8;
    localparam int unsigned GRP_N = 7;
    localparam logic [5:0]  GRP_PAD = 6'd4;

    // configuration registers
    localparam logic [6:0] TOTAL_RST = 7'd32;
    localparam logic [5:0] EXP_RST   = 6'd8;
    localparam logic       CFG_TOTAL = 1'b0;
    localparam logic       CFG_EXP   = 1'b1;

    // value class carried down the pipe
    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_INF,
        KIND_NAN,
        KIND_NORM,
        KIND_SUB
    } t_kind;

    // channel payloads
    typedef struct packed {
        logic [63:0] double_bits;
    } t_in;

    typedef struct packed {
        logic [63:0] narrow_bits;
        logic        bad_setting;
    } t_out;

    // values derived from the two width registers
    typedef struct packed {
        logic        bad;
        logic [5:0]  f;          // fraction width
        logic [61:0] bias;       // 2^(e-1)-1
        logic [61:0] exp_max;    // 2^e-1
        logic [63:0] exp_ones;   // all-ones exponent in place
        logic [63:0] sign_mask;  // bit t-1
        logic [63:0] nan_bit;    // bit f-1
        logic [5:0]  fsh;        // 64-f
        logic [11:0] sofs;       // 64-bias-f, low 12 bits
    } t_cfg;

    // stage 1: decoded fields and per-group leading zeros
    typedef struct packed {
        logic                      sign;
        t_kind                     kind;
        logic [DEXP_W-1:0]         dexp;
        logic [FRAC_W-1:0]         frac;
        logic [GRP_N-1:0]          grp_nz;
        logic [GRP_N-1:0][2:0]     grp_lz;
    } t_s1;

    // stage 2: unbiased exponent and normalized fraction
    typedef struct packed {
        logic              sign;
        t_kind             kind;
        logic [11:0]       unb;
        logic [FRAC_W-1:0] frac;
    } t_s2;

    // stage 3: rebiased exponent and final class
    typedef struct packed {
        logic              sign;
        t_kind             kind;
        logic [61:0]       be;
        logic [FRAC_W-1:0] frac;
        logic [5:0]        sh_sub;
        logic              sub_zero;
    } t_s3;

    // leading zeros of one 8-bit group
    function automatic logic [2:0] grp_lz(input logic [GRP_W-1:0] g);
        logic [2:0] lz;
        lz = 3'd0;
        for (int i = 0; i < GRP_W; i++) begin
            if (g[i]) begin
                lz = 3'(GRP_W - 1 - i);
            end
        end
        return lz;
    endfunction

endpackage

[rtl/dtcf_stream_if.sv]
// ============================================================================
// dtcf_stream_if
// Valid/ready channel carrying one payload of a given type.
// ============================================================================
interface dtcf_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/dtcf_decode.sv]
// ============================================================================
// dtcf_decode
// Stages 1 and 2: field decode, grouped leading-one search, normalization.
// ============================================================================
module dtcf_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dtcf_stream_if.sink          i_s,
    dtcf_stream_if.source        o_s
);

    logic           r_v1, r_v2;
    dtcf_pkg::t_s1  r_s1, n_s1;
    dtcf_pkg::t_s2  r_s2, n_s2;
    logic           en1, en2;

    // stage enables: a stage moves when empty or when the next one moves
    assign en2       = !r_v2 || o_s.ready;
    assign en1       = !r_v1 || en2;
    assign i_s.ready = en1;
    assign o_s.valid = r_v2;
    assign o_s.data  = r_s2;

    // stage 1: split fields, classify, per-group leading zeros
    always_comb begin
        logic [63:0]                x;
        logic [55:0]                v56;
        logic [dtcf_pkg::GRP_W-1:0] grp;
        x    = i_s.data.double_bits;
        v56  = {4'b0, x[dtcf_pkg::FRAC_W-1:0]};
        n_s1 = '0;
        n_s1.sign = x[63];
        n_s1.dexp = x[62:52];
        n_s1.frac = x[dtcf_pkg::FRAC_W-1:0];
        for (int g = 0; g < dtcf_pkg::GRP_N; g++) begin
            grp            = v56[g*dtcf_pkg::GRP_W +: dtcf_pkg::GRP_W];
            n_s1.grp_nz[g] = |grp;
            n_s1.grp_lz[g] = dtcf_pkg::grp_lz(grp);
        end
        if (n_s1.dexp == '0 && n_s1.frac == '0) begin
            n_s1.kind = dtcf_pkg::KIND_ZERO;
        end else if (n_s1.dexp == dtcf_pkg::DEXP_ONES) begin
            n_s1.kind = (n_s1.frac != '0) ? dtcf_pkg::KIND_NAN : dtcf_pkg::KIND_INF;
        end else begin
            n_s1.kind = dtcf_pkg::KIND_NORM;
        end
    end

    // stage 2: pick the top nonzero group, normalize subnormals
    always_comb begin
        logic [2:0]  sel;
        logic [5:0]  lz56;
        logic [5:0]  lz;
        logic [52:0] sh;
        logic [11:0] ue;
        sel = 3'd0;
        for (int g = 0; g < dtcf_pkg::GRP_N; g++) begin
            if (r_s1.grp_nz[g]) begin
                sel = 3'(g);
            end
        end
        lz56 = {3'(dtcf_pkg::GRP_N - 1) - sel, r_s1.grp_lz[sel]};
        lz   = lz56 - dtcf_pkg::GRP_PAD;
        // the leading one lands in bit 52 and drops off
        sh   = {r_s1.frac, 1'b0} << lz;
        ue   = (r_s1.dexp == '0) ? (12'd0 - {6'd0, lz}) : {1'b0, r_s1.dexp};
        n_s2.sign = r_s1.sign;
        n_s2.kind = r_s1.kind;
        n_s2.unb  = ue - dtcf_pkg::DBL_BIAS;
        n_s2.frac = (r_s1.dexp == '0) ? sh[dtcf_pkg::FRAC_W-1:0] : r_s1.frac;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_s.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1 && i_s.valid) begin
            r_s1 <= n_s1;
        end
        if (en2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    // a stalled item in stage 2 stays put
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !o_s.ready |=> r_v2 && $stable(r_s2))
        else $error("stage 2 item lost under stall");

endmodule

[rtl/dtcf_rebias.sv]
// ============================================================================
// dtcf_rebias
// Stage 3: rebias the exponent, resolve overflow/normal/subnormal.
// ============================================================================
module dtcf_rebias (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dtcf_pkg::t_cfg       i_cfg,
    dtcf_stream_if.sink          i_s,
    dtcf_stream_if.source        o_s
);

    logic           r_v;
    dtcf_pkg::t_s3  r_s3, n_s3;
    dtcf_pkg::t_s2  s2;
    logic           en;

    assign s2        = i_s.data;
    assign en        = !r_v || o_s.ready;
    assign i_s.ready = en;
    assign o_s.valid = r_v;
    assign o_s.data  = r_s3;

    // target exponent and class
    always_comb begin
        logic [63:0] be;
        logic        ovf;
        logic        pos;
        logic [11:0] s12;
        be  = {{52{s2.unb[11]}}, s2.unb} + {2'b0, i_cfg.bias};
        ovf = !be[63] && (be[62:0] >= {1'b0, i_cfg.exp_max});
        pos = !be[63] && (be != '0);
        // right shift of the significand for subnormals: 11-k
        s12 = i_cfg.sofs - s2.unb;
        n_s3.sign     = s2.sign;
        n_s3.be       = be[61:0];
        n_s3.frac     = s2.frac;
        n_s3.sh_sub   = s12[5:0];
        n_s3.sub_zero = (s12[11:6] != '0);
        n_s3.kind     = s2.kind;
        if (s2.kind == dtcf_pkg::KIND_NORM) begin
            if (ovf) begin
                n_s3.kind = dtcf_pkg::KIND_INF;
            end else if (!pos) begin
                n_s3.kind = dtcf_pkg::KIND_SUB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_s.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_s.valid) begin
            r_s3 <= n_s3;
        end
    end

    // a held item is not dropped while the output stalls
    a_s3_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !o_s.ready |=> r_v)
        else $error("stage 3 item dropped under stall");

endmodule

[rtl/dtcf_pack.sv]
// ============================================================================
// dtcf_pack
// Stage 4: align fraction and exponent, assemble the result word.
// ============================================================================
module dtcf_pack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dtcf_pkg::t_cfg       i_cfg,
    dtcf_stream_if.sink          i_s,
    dtcf_stream_if.source        o_s
);

    logic            r_v;
    dtcf_pkg::t_out  r_out, n_out;
    dtcf_pkg::t_s3   s3;
    logic            en;

    assign s3        = i_s.data;
    assign en        = !r_v || o_s.ready;
    assign i_s.ready = en;
    assign o_s.valid = r_v;
    assign o_s.data  = r_out;

    // result assembly
    always_comb begin
        logic [63:0] sgn;
        logic [63:0] norm_fr;
        logic [63:0] exp_f;
        logic [63:0] sub_fr;
        logic [63:0] res;
        sgn     = s3.sign ? i_cfg.sign_mask : 64'd0;
        // fraction sits at the top, one shift covers truncate and extend
        norm_fr = {s3.frac, 12'b0} >> i_cfg.fsh;
        exp_f   = {2'b0, s3.be} << i_cfg.f;
        sub_fr  = s3.sub_zero ? 64'd0 : ({1'b1, s3.frac, 11'b0} >> s3.sh_sub);
        case (s3.kind)
            dtcf_pkg::KIND_ZERO: res = sgn;
            dtcf_pkg::KIND_INF:  res = sgn | i_cfg.exp_ones;
            dtcf_pkg::KIND_NAN:  res = sgn | i_cfg.exp_ones | i_cfg.nan_bit;
            dtcf_pkg::KIND_NORM: res = sgn | exp_f | norm_fr;
            dtcf_pkg::KIND_SUB:  res = sgn | sub_fr;
            default:             res = sgn;
        endcase
        if (i_cfg.bad) begin
            n_out.narrow_bits = 64'd0;
            n_out.bad_setting = 1'b1;
        end else begin
            n_out.narrow_bits = res;
            n_out.bad_setting = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_s.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_s.valid) begin
            r_out <= n_out;
        end
    end

    // a bad width pair always comes out as zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_out.bad_setting |-> r_out.narrow_bits == 64'd0)
        else $error("bad setting with nonzero result");

endmodule

[rtl/double_to_custom_float.sv]
// ============================================================================
// double_to_custom_float
// Converts binary64 bit patterns into a float of configurable widths.
// ============================================================================
// Usage:
//   i_dbl carries one binary64 pattern per transaction; o_res returns the
//   converted word, right-aligned, plus a flag for an invalid width pair.
//   Both channels are valid/ready; a transaction completes when both are high.
//   The target format is set through the write port: index 0 is the total
//   width, index 1 the exponent width. Write only while no transaction is in
//   flight; a new setting applies to items accepted from the next cycle on.
// Throughput: one transaction per clock, sustained while o_res takes every result.
// Pipeline: the four stages are decode, normalize, rebias (64-bit add
//   and compare) and pack (barrel shifts).
// Reset: clears all pipeline valid bits and loads 32 total / 8 exponent bits.
// Stall: when o_res is not taken, results stay in place and the pipeline
//   compresses bubbles; i_dbl.ready drops only once every stage is full.
// ============================================================================
module double_to_custom_float (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [6:0]           i_cfg_wdata,
    dtcf_stream_if.sink          i_dbl,
    dtcf_stream_if.source        o_res
);

    logic [6:0]      r_total_bits;
    logic [5:0]      r_exp_bits;
    dtcf_pkg::t_cfg  r_cfg, n_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_bits <= dtcf_pkg::TOTAL_RST;
            r_exp_bits   <= dtcf_pkg::EXP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtcf_pkg::CFG_TOTAL: r_total_bits <= i_cfg_wdata;
                dtcf_pkg::CFG_EXP:   r_exp_bits   <= i_cfg_wdata[5:0];
            endcase
        end
    end

    // derived format constants, refreshed every cycle
    always_comb begin
        logic [6:0]  t;
        logic [6:0]  e7;
        logic [6:0]  f7;
        logic [6:0]  tm1;
        logic [6:0]  fsh7;
        logic [5:0]  em1;
        logic [5:0]  fm1;
        logic [61:0] bias;
        logic [61:0] emax;
        t    = r_total_bits;
        e7   = {1'b0, r_exp_bits};
        f7   = t - 7'd1 - e7;
        tm1  = t - 7'd1;
        fsh7 = 7'd64 - f7;
        em1  = r_exp_bits - 6'd1;
        fm1  = f7[5:0] - 6'd1;
        bias = (62'd1 << em1) - 62'd1;
        emax = (62'd1 << r_exp_bits) - 62'd1;
        n_cfg.bad       = (t < 7'd3) || (t > 7'd64) || (r_exp_bits == 6'd0)
                          || (e7 + 7'd2 > t);
        n_cfg.f         = f7[5:0];
        n_cfg.bias      = bias;
        n_cfg.exp_max   = emax;
        n_cfg.exp_ones  = {2'b0, emax} << f7[5:0];
        n_cfg.sign_mask = 64'd1 << tm1[5:0];
        n_cfg.nan_bit   = 64'd1 << fm1;
        n_cfg.fsh       = fsh7[5:0];
        n_cfg.sofs      = 12'd64 - bias[11:0] - {5'd0, f7};
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // pipeline
    dtcf_stream_if #(.t_data(dtcf_pkg::t_s2)) s2_if ();
    dtcf_stream_if #(.t_data(dtcf_pkg::t_s3)) s3_if ();

    dtcf_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s     (i_dbl),
        .o_s     (s2_if)
    );

    dtcf_rebias u_rebias (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_s     (s2_if),
        .o_s     (s3_if)
    );

    dtcf_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_s     (s3_if),
        .o_s     (o_res)
    );

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("output valid right after reset");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double to custom float converter.
// A driver process feeds binary64 patterns from a queue over a valid/ready
// channel with random gaps. A monitor process takes results with random
// stalls and compares each one with the value predicted for it. The target
// format is reprogrammed between phases while the pipeline is empty. The
// phases cover the widest and narrowest formats and several invalid width
// pairs.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SQUEEZE_LEN = 300;
    localparam int DRAIN_WAIT  = 12;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [6:0] i_cfg_wdata;

    dtcf_stream_if #(.t_data(dtcf_pkg::t_in))  dbl_if ();
    dtcf_stream_if #(.t_data(dtcf_pkg::t_out)) res_if ();

    double_to_custom_float dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_dbl       (dbl_if.sink),
        .o_res       (res_if.source)
    );

    // Target format as the bench believes it is programmed
    logic [6:0] total_w;
    logic [5:0] exp_w;

    logic [63:0]    double_feed_q[$];
    dtcf_pkg::t_out narrow_due_q[$];

    logic        burst_mode;
    int          miss_count   = 0;
    int          result_count = 0;
    int          cycle_count  = 0;

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Predicted conversion of one binary64 pattern into the current format
    function automatic dtcf_pkg::t_out convert_double(input logic [63:0] x,
                                                      input logic [6:0] tw,
                                                      input logic [5:0] ew);
        dtcf_pkg::t_out r;
        int          t;
        int          e;
        int          f;
        int          p;
        logic [10:0] dexp;
        logic [51:0] dfrac;
        logic [63:0] sign_b;
        logic [63:0] ones_b;
        logic [63:0] res;
        logic [63:0] frac52;
        logic [63:0] sig;
        logic [63:0] fr;
        longint      unb;
        longint      bias;
        longint      be;
        longint      emax;
        longint      k;
        t = tw;
        e = ew;
        r.narrow_bits = '0;
        r.bad_setting = 1'b1;
        if (t < 3 || t > 64 || e < 1 || e + 2 > t) return r;
        r.bad_setting = 1'b0;
        f      = t - 1 - e;
        sign_b = x[63] ? (64'd1 << (t - 1)) : 64'd0;
        dexp   = x[62:52];
        dfrac  = x[51:0];
        ones_b = ((64'd1 << e) - 64'd1) << f;
        if (dexp == '0 && dfrac == '0) begin
            res = sign_b;
        end else if (dexp == dtcf_pkg::DEXP_ONES) begin
            // infinity, or NaN with only the top fraction bit kept
            res = sign_b | ones_b;
            if (dfrac != '0) res |= 64'd1 << (f - 1);
        end else begin
            if (dexp == '0) begin
                // subnormal double: normalize on the leading one
                p = 0;
                for (int i = 0; i < 52; i++) begin
                    if (dfrac[i]) p = i;
                end
                unb    = p - 1074;
                frac52 = ({12'd0, dfrac} << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF;
            end else begin
                unb    = longint'(dexp) - 1023;
                frac52 = {12'd0, dfrac};
            end
            bias = (longint'(1) << (e - 1)) - 1;
            emax = (longint'(1) << e) - 1;
            be   = unb + bias;
            if (be >= emax) begin
                res = sign_b | ones_b;
            end else if (be >= 1) begin
                fr  = (f <= 52) ? (frac52 >> (52 - f)) : (frac52 << (f - 52));
                res = sign_b | (64'(be) << f) | fr;
            end else begin
                // underflow: truncated subnormal with the hidden one
                sig = frac52 | (64'd1 << 52);
                k   = be - 53 + f;
                if (k >= 0) fr = sig << k;
                else if (k <= -64) fr = '0;
                else fr = sig >> (-k);
                res = sign_b | fr;
            end
        end
        if (t < 64) res &= (64'd1 << t) - 64'd1;
        r.narrow_bits = res;
        return r;
    endfunction

    // Random pattern, biased toward exponents the target format can hold
    function automatic logic [63:0] random_double(input int e, input int f);
        logic [63:0] x;
        int          sel;
        int          span;
        int          de;
        x   = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            x[62:52] = $urandom_range(0, 1) ? dtcf_pkg::DEXP_ONES : 11'h000;
            if ($urandom_range(0, 2) == 0) x[51:0] = '0;
        end else if (sel < 60 && e >= 1 && e <= 10) begin
            span = (1 << (e - 1)) + f + 3;
            de   = 1023 - span + $urandom_range(0, 2 * span);
            if (de < 1) de = 1;
            if (de > 2046) de = 2046;
            x[62:52] = de[10:0];
        end
        return x;
    endfunction

    // Driver: presents queued patterns, holds each until taken
    int feed_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dbl_if.valid <= 1'b0;
            dbl_if.data  <= '0;
            feed_gap     <= 0;
        end else begin
            if (dbl_if.valid && dbl_if.ready) begin
                narrow_due_q.push_back(convert_double(dbl_if.data.double_bits, total_w, exp_w));
            end
            if (!(dbl_if.valid && !dbl_if.ready)) begin
                if (feed_gap > 0) begin
                    feed_gap     <= feed_gap - 1;
                    dbl_if.valid <= 1'b0;
                end else if (double_feed_q.size() != 0) begin
                    dbl_if.data.double_bits <= double_feed_q.pop_front();
                    dbl_if.valid            <= 1'b1;
                    feed_gap                <= pick_gap();
                end else begin
                    dbl_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls, occasional long hold-off, result checking
    int             stall_cnt;
    int             squeeze_cnt;
    int             next_squeeze;
    dtcf_pkg::t_out got;
    dtcf_pkg::t_out want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_cnt    <= 0;
            squeeze_cnt  <= 0;
            next_squeeze <= 400;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got          = res_if.data;
                result_count = result_count + 1;
                if (narrow_due_q.size() == 0) begin
                    miss_count = miss_count + 1;
                    if (miss_count <= 10)
                        $display("unexpected result: narrow_bits=%h bad_setting=%b",
                                 got.narrow_bits, got.bad_setting);
                end else begin
                    want = narrow_due_q.pop_front();
                    if (got.narrow_bits !== want.narrow_bits ||
                        got.bad_setting !== want.bad_setting) begin
                        miss_count = miss_count + 1;
                        if (miss_count <= 10)
                            $display("mismatch: narrow_bits exp=%h got=%h bad_setting exp=%b got=%b",
                                     want.narrow_bits, got.narrow_bits,
                                     want.bad_setting, got.bad_setting);
                    end
                end
            end
            if (squeeze_cnt > 0) begin
                squeeze_cnt  <= squeeze_cnt - 1;
                res_if.ready <= 1'b0;
            end else if (result_count >= next_squeeze && double_feed_q.size() > 50) begin
                // long hold-off so the pipeline fills and backpressures
                squeeze_cnt  <= SQUEEZE_LEN;
                next_squeeze <= next_squeeze + 900;
                res_if.ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt    <= stall_cnt - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_cnt <= pick_gap();
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Wait until nothing is queued, offered or outstanding
    task automatic wait_idle();
        do @(posedge i_clk);
        while (double_feed_q.size() != 0 || dbl_if.valid || narrow_due_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == dtcf_pkg::CFG_TOTAL) total_w = val;
        else exp_w = val[5:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Formats per phase: total width, exponent width, item count
    int phase_t[16] = '{32,  3, 64, 64, 16, 64, 40,  8, 127, 10, 64, 32,  0, 24, 53, 12};
    int phase_e[16] = '{ 8,  1, 62, 11,  5,  1, 20,  4,   8,  9, 63,  0,  0, 22, 10,  3};
    int phase_n[16] = '{150,148,148,148,148,148,148,148, 40, 40, 40, 40, 30,148,148,148};

    logic [63:0] directed[25] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
        64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_1234, 64'h7FF0_0000_0000_0001,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
        64'h7FEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'h000F_FFFF_FFFF_FFFF, 64'h8008_0000_0000_0000, 64'h7E37_E43C_8800_759C,
        64'h01A5_6E1F_C2F8_F359, 64'h3810_0000_0000_0000, 64'h36A0_0000_0000_0000,
        64'h3690_0000_0000_0000, 64'h47E0_0000_0000_0000, 64'h47F0_0000_0000_0000,
        64'h4009_21FB_5444_2D18, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA
    };

    // Stimulus sequence
    initial begin
        int f_w;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = dtcf_pkg::CFG_TOTAL;
        i_cfg_wdata  = '0;
        total_w      = dtcf_pkg::TOTAL_RST;
        exp_w        = dtcf_pkg::EXP_RST;
        burst_mode   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed patterns in the reset format
        foreach (directed[i]) double_feed_q.push_back(directed[i]);

        for (int ph = 0; ph < 16; ph++) begin
            if (ph != 0) begin
                wait_idle();
                write_reg(dtcf_pkg::CFG_TOTAL, phase_t[ph][6:0]);
                write_reg(dtcf_pkg::CFG_EXP, phase_e[ph][6:0]);
            end
            burst_mode = (ph % 4 == 2);
            f_w = phase_t[ph] - 1 - phase_e[ph];
            for (int n = 0; n < phase_n[ph]; n++)
                double_feed_q.push_back(random_double(phase_e[ph], f_w));
        end

        // Drain and let the pipeline settle
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (miss_count == 0 && narrow_due_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
